/* hdl/ngga_pkg.sv */
// Shared types, constants and helper functions for the GGA position parser.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
`timescale 1ns / 1ps

package ngga_pkg;

	localparam int MIN_FRAC_DIGITS = 4;
	localparam int INT_DIGITS      = 5;

	localparam int FRAC_SCALE = 10 ** MIN_FRAC_DIGITS;
	localparam int FRAC_W     = $clog2(FRAC_SCALE);
	localparam int INT_W      = $clog2(10 ** INT_DIGITS);
	localparam int P6         = 10 ** (6 - MIN_FRAC_DIGITS);

	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int LANE_STAGES = 5;

	// coordinate conversion widths
	localparam int R100_W    = 18;
	localparam int DIV_SHIFT = 24;
	localparam int PR_W      = INT_W + R100_W;
	localparam int DEG_W     = PR_W - DIV_SHIFT;
	localparam int MM_W      = 7;
	localparam int Y_W       = 27;
	localparam int Z_W       = Y_W - 2;
	localparam int V_W       = 30;
	localparam int PQ_W      = 2 * Z_W;
	localparam int M15_SHIFT = 28;
	localparam int Q_W       = PQ_W - M15_SHIFT;
	localparam int OUT_W     = 31;

	localparam logic [R100_W-1:0] R100     = 18'd167773;
	localparam logic [Z_W-1:0]    M15      = 25'd17895697;
	localparam logic [Z_W-1:0]    FIFTEEN  = 25'd15;
	localparam logic [V_W-1:0]    UDEG     = 30'd1000000;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOTGGA = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;

	typedef enum logic [3:0] {
		PH_PREFIX,
		PH_COMMA0,
		PH_TIME,
		PH_COMMA1,
		PH_LAT_INT,
		PH_LAT_FRAC,
		PH_LAT_HEMI,
		PH_COMMA_LH,
		PH_LON_INT,
		PH_LON_FRAC,
		PH_LON_HEMI,
		PH_DONE,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [INT_W-1:0]  lat_int;
		logic [FRAC_W-1:0] lat_frac;
		logic              south;
		logic [INT_W-1:0]  lon_int;
		logic [FRAC_W-1:0] lon_frac;
		logic              west;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [7:0] gga_tag(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h24;
			3'd1: ch = 8'h47;
			3'd2: ch = 8'h50;
			3'd3: ch = 8'h47;
			3'd4: ch = 8'h47;
			3'd5: ch = 8'h41;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// 10^(MIN_FRAC_DIGITS - cnt): pads a short fraction with zeros
	function automatic logic [FRAC_W-1:0] pad_mult(input logic [2:0] cnt);
		logic [FRAC_W-1:0] m;
		m = FRAC_W'(1);
		for (int i = 0; i < MIN_FRAC_DIGITS; i++) begin
			if (i >= int'(cnt)) begin
				m = FRAC_W'(m * FRAC_W'(10));
			end
		end
		return m;
	endfunction

endpackage

/* hdl/nmea_gga_position_parser.sv */
// GGA position parser top: byte parser front, four-entry job queue, converter back.
// Between the beat carrying tlast and m_tvalid: queue, five lane stages, output register.
// Throughput: one byte per cycle while the queue is not full; one result per sentence, set
// by the byte-serial parser; the back end takes a new job each cycle unless m_tready stalls.
// Reset: arst_n asynchronous, active low; clears parser state, queue and valid flags.
// Depends on ngga_pkg, ngga_front, ngga_fifo, ngga_back.
`timescale 1ns / 1ps

module nmea_gga_position_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [1:0] status, [32:2] lat_udeg, [63:33] lon_udeg
);

	ngga_pkg::job_t       push_job, head_job;
	ngga_pkg::fifo_stat_t stat;
	logic                 push, pop;

	assign s_tready = !stat.full;

	ngga_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.push     (push),
		.job      (push_job)
	);

	ngga_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (head_job),
		.stat   (stat)
	);

	ngga_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (head_job),
		.stat     (stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* hdl/ngga_front.sv */
// Byte-level sentence parser: walks the GGA fields and hands one job per sentence.
// Depends on ngga_pkg.
`timescale 1ns / 1ps

module ngga_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] char_byte
	input  logic                s_tlast,   // is_last
	output logic                push,
	output ngga_pkg::job_t      job
);

	ngga_pkg::phase_t              phase_q, nxt_phase;
	logic [2:0]                    cnt_q, nxt_cnt;
	logic [1:0]                    err_q, nxt_err;
	logic [ngga_pkg::INT_W-1:0]    lat_int_q, nxt_lat_int;
	logic [ngga_pkg::FRAC_W-1:0]   lat_frac_q, nxt_lat_frac;
	logic [ngga_pkg::INT_W-1:0]    lon_int_q, nxt_lon_int;
	logic [ngga_pkg::FRAC_W-1:0]   lon_frac_q, nxt_lon_frac;
	logic [2:0]                    fcnt_q, nxt_fcnt;
	logic                          south_q, nxt_south;
	logic                          west_q, nxt_west;

	logic                          digit;
	logic [3:0]                    dval;
	logic                          sel_lat;
	logic [ngga_pkg::INT_W-1:0]    cur_ip, ip_acc;
	logic [ngga_pkg::FRAC_W-1:0]   cur_fp, fp_acc, fp_pad;
	logic [2*ngga_pkg::FRAC_W-1:0] pad_prod;
	logic                          beat;

	assign beat    = s_tvalid && s_tready;
	assign digit   = s_tdata inside {[8'h30:8'h39]};
	assign dval    = 4'(s_tdata - ngga_pkg::CH_ZERO);
	assign sel_lat = (phase_q == ngga_pkg::PH_LAT_INT) || (phase_q == ngga_pkg::PH_LAT_FRAC);
	assign cur_ip  = sel_lat ? lat_int_q : lon_int_q;
	assign cur_fp  = sel_lat ? lat_frac_q : lon_frac_q;
	assign ip_acc  = ngga_pkg::INT_W'(cur_ip * ngga_pkg::INT_W'(10) + ngga_pkg::INT_W'(dval));
	assign fp_acc  = ngga_pkg::FRAC_W'(cur_fp * ngga_pkg::FRAC_W'(10) +
		ngga_pkg::FRAC_W'(dval));
	assign pad_prod = (2*ngga_pkg::FRAC_W)'(cur_fp) *
		(2*ngga_pkg::FRAC_W)'(ngga_pkg::pad_mult(fcnt_q));
	assign fp_pad  = pad_prod[ngga_pkg::FRAC_W-1:0];

	// next state
	always_comb begin
		nxt_phase    = phase_q;
		nxt_cnt      = cnt_q;
		nxt_err      = err_q;
		nxt_lat_int  = lat_int_q;
		nxt_lat_frac = lat_frac_q;
		nxt_lon_int  = lon_int_q;
		nxt_lon_frac = lon_frac_q;
		nxt_fcnt     = fcnt_q;
		nxt_south    = south_q;
		nxt_west     = west_q;
		case (phase_q)
			ngga_pkg::PH_PREFIX: begin
				if (s_tdata == ngga_pkg::gga_tag(cnt_q)) begin
					if (cnt_q == 3'd5) begin
						nxt_cnt   = 3'd0;
						nxt_phase = ngga_pkg::PH_COMMA0;
					end else begin
						nxt_cnt = cnt_q + 3'd1;
					end
				end else begin
					nxt_err   = ngga_pkg::ST_NOTGGA;
					nxt_phase = ngga_pkg::PH_SKIP;
				end
			end
			ngga_pkg::PH_COMMA0: begin
				if (s_tdata == ngga_pkg::CH_COMMA) begin
					nxt_phase = ngga_pkg::PH_TIME;
				end else begin
					nxt_err   = ngga_pkg::ST_BAD;
					nxt_phase = ngga_pkg::PH_SKIP;
				end
			end
			ngga_pkg::PH_TIME: begin
				if (!digit) begin
					nxt_err   = ngga_pkg::ST_BAD;
					nxt_phase = ngga_pkg::PH_SKIP;
				end else if (cnt_q == 3'd5) begin
					nxt_cnt   = 3'd0;
					nxt_phase = ngga_pkg::PH_COMMA1;
				end else begin
					nxt_cnt = cnt_q + 3'd1;
				end
			end
			ngga_pkg::PH_COMMA1, ngga_pkg::PH_COMMA_LH: begin
				if (s_tdata == ngga_pkg::CH_COMMA) begin
					nxt_cnt   = 3'd0;
					nxt_phase = (phase_q == ngga_pkg::PH_COMMA1) ? ngga_pkg::PH_LAT_INT :
						ngga_pkg::PH_LON_INT;
				end else begin
					nxt_err   = ngga_pkg::ST_BAD;
					nxt_phase = ngga_pkg::PH_SKIP;
				end
			end
			ngga_pkg::PH_LAT_INT, ngga_pkg::PH_LON_INT: begin
				if (digit) begin
					if (cnt_q >= 3'(ngga_pkg::INT_DIGITS)) begin
						nxt_err   = ngga_pkg::ST_BAD;
						nxt_phase = ngga_pkg::PH_SKIP;
					end else begin
						if (sel_lat) nxt_lat_int = ip_acc;
						else nxt_lon_int = ip_acc;
						nxt_cnt = cnt_q + 3'd1;
					end
				end else if (s_tdata == ngga_pkg::CH_DOT && cnt_q != 3'd0) begin
					nxt_fcnt  = 3'd0;
					nxt_phase = sel_lat ? ngga_pkg::PH_LAT_FRAC : ngga_pkg::PH_LON_FRAC;
				end else if (s_tdata == ngga_pkg::CH_COMMA && cnt_q != 3'd0) begin
					nxt_phase = sel_lat ? ngga_pkg::PH_LAT_HEMI : ngga_pkg::PH_LON_HEMI;
				end else begin
					nxt_err   = ngga_pkg::ST_BAD;
					nxt_phase = ngga_pkg::PH_SKIP;
				end
			end
			ngga_pkg::PH_LAT_FRAC, ngga_pkg::PH_LON_FRAC: begin
				if (digit) begin
					if (fcnt_q < 3'(ngga_pkg::MIN_FRAC_DIGITS)) begin
						if (sel_lat) nxt_lat_frac = fp_acc;
						else nxt_lon_frac = fp_acc;
						nxt_fcnt = fcnt_q + 3'd1;
					end
				end else if (s_tdata == ngga_pkg::CH_COMMA) begin
					if (sel_lat) nxt_lat_frac = fp_pad;
					else nxt_lon_frac = fp_pad;
					nxt_fcnt  = 3'(ngga_pkg::MIN_FRAC_DIGITS);
					nxt_phase = sel_lat ? ngga_pkg::PH_LAT_HEMI : ngga_pkg::PH_LON_HEMI;
				end else begin
					nxt_err   = ngga_pkg::ST_BAD;
					nxt_phase = ngga_pkg::PH_SKIP;
				end
			end
			ngga_pkg::PH_LAT_HEMI: begin
				nxt_south = (s_tdata == ngga_pkg::CH_S);
				nxt_phase = ngga_pkg::PH_COMMA_LH;
			end
			ngga_pkg::PH_LON_HEMI: begin
				nxt_west  = (s_tdata == ngga_pkg::CH_W);
				nxt_phase = ngga_pkg::PH_DONE;
			end
			default: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		push         = beat && s_tlast;
		job.lat_int  = nxt_lat_int;
		job.lat_frac = nxt_lat_frac;
		job.south    = nxt_south;
		job.lon_int  = nxt_lon_int;
		job.lon_frac = nxt_lon_frac;
		job.west     = nxt_west;
		if (nxt_err != ngga_pkg::ST_OK) job.status = nxt_err;
		else if (nxt_phase == ngga_pkg::PH_PREFIX) job.status = ngga_pkg::ST_NOTGGA;
		else if (nxt_phase != ngga_pkg::PH_DONE) job.status = ngga_pkg::ST_BAD;
		else job.status = ngga_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ngga_pkg::PH_PREFIX;
			cnt_q      <= '0;
			err_q      <= ngga_pkg::ST_OK;
			lat_int_q  <= '0;
			lat_frac_q <= '0;
			lon_int_q  <= '0;
			lon_frac_q <= '0;
			fcnt_q     <= '0;
			south_q    <= 1'b0;
			west_q     <= 1'b0;
		end else if (beat) begin
			if (s_tlast) begin
				phase_q    <= ngga_pkg::PH_PREFIX;
				cnt_q      <= '0;
				err_q      <= ngga_pkg::ST_OK;
				lat_int_q  <= '0;
				lat_frac_q <= '0;
				lon_int_q  <= '0;
				lon_frac_q <= '0;
				fcnt_q     <= '0;
				south_q    <= 1'b0;
				west_q     <= 1'b0;
			end else begin
				phase_q    <= nxt_phase;
				cnt_q      <= nxt_cnt;
				err_q      <= nxt_err;
				lat_int_q  <= nxt_lat_int;
				lat_frac_q <= nxt_lat_frac;
				lon_int_q  <= nxt_lon_int;
				lon_frac_q <= nxt_lon_frac;
				fcnt_q     <= nxt_fcnt;
				south_q    <= nxt_south;
				west_q     <= nxt_west;
			end
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(beat && s_tlast) |=> (phase_q == ngga_pkg::PH_PREFIX && cnt_q == 3'd0))
		else $error("parser not back at prefix after last beat");

	a_err_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ngga_pkg::ST_OK) |-> (phase_q == ngga_pkg::PH_SKIP))
		else $error("error latched outside skip phase");

endmodule

/* hdl/ngga_fifo.sv */
// Short job queue between the parser and the converter pipeline.
// Depends on ngga_pkg.
`timescale 1ns / 1ps

module ngga_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ngga_pkg::job_t       wr_job,
	input  logic                 pop,
	output ngga_pkg::job_t       rd_job,
	output ngga_pkg::fifo_stat_t stat
);

	ngga_pkg::job_t                mem_q [ngga_pkg::FIFO_DEPTH];
	logic [ngga_pkg::PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [ngga_pkg::PTR_W:0]      count_q;

	assign rd_job     = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == (ngga_pkg::PTR_W+1)'(ngga_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + ngga_pkg::PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + ngga_pkg::PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (ngga_pkg::PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (ngga_pkg::PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/ngga_coord.sv */
// One coordinate lane: (d)ddmm.mmmm fixed-point digits to micro-degree magnitude.
// Five register stages, constant multiplies only. Depends on ngga_pkg.
`timescale 1ns / 1ps

module ngga_coord (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ngga_pkg::INT_W-1:0]  ip,
	input  logic [ngga_pkg::FRAC_W-1:0] fp,
	input  logic                        neg,
	output logic [ngga_pkg::V_W-1:0]    mag,
	output logic                        mag_neg
);

	logic [ngga_pkg::PR_W-1:0]   pr_s1;
	logic [ngga_pkg::INT_W-1:0]  ip_s1;
	logic [ngga_pkg::FRAC_W-1:0] fp_s1, fp_s2;
	logic                        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [ngga_pkg::DEG_W-1:0]  deg, deg_s2;
	logic [ngga_pkg::INT_W-1:0]  rem;
	logic [ngga_pkg::MM_W-1:0]   mm_s2;
	logic [ngga_pkg::Y_W-1:0]    y_s3;
	logic [ngga_pkg::V_W-1:0]    degu_s3, degu_s4, mag_s5;
	logic [ngga_pkg::PQ_W-1:0]   pq_s4;
	logic [ngga_pkg::Z_W-1:0]    z_s4, r;
	logic [ngga_pkg::Q_W-1:0]    q0, q;

	// degrees = ip / 100 by reciprocal; minutes = remainder
	assign deg = pr_s1[ngga_pkg::PR_W-1:ngga_pkg::DIV_SHIFT];
	assign rem = ip_s1 - ngga_pkg::INT_W'(ngga_pkg::INT_W'(deg) * ngga_pkg::INT_W'(100));

	// floor(z / 15) estimate is low by at most one
	assign q0 = pq_s4[ngga_pkg::PQ_W-1:ngga_pkg::M15_SHIFT];
	assign r  = z_s4 - ngga_pkg::Z_W'({q0, 4'b0000} - {4'b0000, q0});
	assign q  = (r >= ngga_pkg::FIFTEEN) ? q0 + ngga_pkg::Q_W'(1) : q0;

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1   <= ngga_pkg::PR_W'(ip) * ngga_pkg::PR_W'(ngga_pkg::R100);
			ip_s1   <= ip;
			fp_s1   <= fp;
			neg_s1  <= neg;

			deg_s2  <= deg;
			mm_s2   <= rem[ngga_pkg::MM_W-1:0];
			fp_s2   <= fp_s1;
			neg_s2  <= neg_s1;

			y_s3    <= ngga_pkg::Y_W'(ngga_pkg::Y_W'(mm_s2) * ngga_pkg::Y_W'(ngga_pkg::UDEG)) +
				ngga_pkg::Y_W'(ngga_pkg::Y_W'(fp_s2) * ngga_pkg::Y_W'(ngga_pkg::P6));
			degu_s3 <= ngga_pkg::V_W'(deg_s2) * ngga_pkg::UDEG;
			neg_s3  <= neg_s2;

			pq_s4   <= ngga_pkg::PQ_W'(y_s3[ngga_pkg::Y_W-1:2]) * ngga_pkg::PQ_W'(ngga_pkg::M15);
			z_s4    <= y_s3[ngga_pkg::Y_W-1:2];
			degu_s4 <= degu_s3;
			neg_s4  <= neg_s3;

			mag_s5  <= degu_s4 + ngga_pkg::V_W'(q);
			neg_s5  <= neg_s4;
		end
	end

	assign mag     = mag_s5;
	assign mag_neg = neg_s5;

endmodule

/* hdl/ngga_back.sv */
// Converter back end: pulls jobs from the queue, runs both lanes, holds the result beat.
// Depends on ngga_pkg and ngga_coord.
`timescale 1ns / 1ps

module ngga_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ngga_pkg::job_t       job,
	input  ngga_pkg::fifo_stat_t stat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [63:0]          m_tdata    // [1:0] status, [32:2] lat_udeg, [63:33] lon_udeg
);

	logic                             advance;
	logic [ngga_pkg::LANE_STAGES-1:0] vld_q;
	logic [1:0]                       st_s [ngga_pkg::LANE_STAGES];
	logic [ngga_pkg::V_W-1:0]         lat_mag, lon_mag;
	logic                             lat_neg, lon_neg;
	logic [ngga_pkg::OUT_W-1:0]       lat_val, lon_val;
	logic                             out_valid_q;
	logic [1:0]                       out_st_q;
	logic [ngga_pkg::OUT_W-1:0]       out_lat_q, out_lon_q;
	logic [1:0]                       st_last;

	assign advance = !out_valid_q || m_tready;
	assign pop     = advance && !stat.empty;
	assign st_last = st_s[ngga_pkg::LANE_STAGES-1];

	ngga_coord u_lat (
		.clk     (clk),
		.en      (advance),
		.ip      (job.lat_int),
		.fp      (job.lat_frac),
		.neg     (job.south),
		.mag     (lat_mag),
		.mag_neg (lat_neg)
	);

	ngga_coord u_lon (
		.clk     (clk),
		.en      (advance),
		.ip      (job.lon_int),
		.fp      (job.lon_frac),
		.neg     (job.west),
		.mag     (lon_mag),
		.mag_neg (lon_neg)
	);

	always_comb begin
		lat_val = '0;
		lon_val = '0;
		if (st_last == ngga_pkg::ST_OK) begin
			lat_val = lat_neg ? ngga_pkg::OUT_W'(0) - ngga_pkg::OUT_W'(lat_mag) :
				ngga_pkg::OUT_W'(lat_mag);
			lon_val = lon_neg ? ngga_pkg::OUT_W'(0) - ngga_pkg::OUT_W'(lon_mag) :
				ngga_pkg::OUT_W'(lon_mag);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s[0] <= job.status;
			for (int i = 1; i < ngga_pkg::LANE_STAGES; i++) begin
				st_s[i] <= st_s[i-1];
			end
			out_st_q  <= st_last;
			out_lat_q <= lat_val;
			out_lon_q <= lon_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			vld_q       <= {vld_q[ngga_pkg::LANE_STAGES-2:0], pop};
			out_valid_q <= vld_q[ngga_pkg::LANE_STAGES-1];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_lon_q, out_lat_q, out_st_q};

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q != ngga_pkg::ST_OK) |-> (out_lat_q == '0 && out_lon_q == '0))
		else $error("nonzero status beat carries coordinates");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

endmodule

/* tb/sv/tb_nmea_gga_position_parser.sv */
// Self-checking testbench for nmea_gga_position_parser: streams GGA sentences byte by byte
// and compares each position result with a local parse-and-convert predictor.
// Depends on ngga_pkg and the nmea_gga_position_parser RTL.
`timescale 1ns / 1ps

module tb_nmea_gga_position_parser;

	localparam int STALL_LIMIT = 1000;
	localparam int TOTAL_BEATS = 650;

	typedef struct {
		logic [1:0]  status;
		logic [30:0] lat;
		logic [30:0] lon;
	} gga_fix_t;

	class gga_scoreboard;
		ngga_pkg::phase_t phase;
		logic [2:0]  cnt;
		logic [1:0]  err;
		logic [16:0] lat_i;
		logic [13:0] lat_f;
		logic [16:0] lon_i;
		logic [13:0] lon_f;
		logic [2:0]  fcnt;
		logic        south;
		logic        west;
		gga_fix_t    pending_fixes[$];
		int          errors;
		int          reported;

		function new();
			errors   = 0;
			reported = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			phase = ngga_pkg::PH_PREFIX;
			cnt   = '0;
			err   = ngga_pkg::ST_OK;
			lat_i = '0;
			lat_f = '0;
			lon_i = '0;
			lon_f = '0;
			fcnt  = '0;
			south = 1'b0;
			west  = 1'b0;
		endfunction

		function void abort_parse(logic [1:0] code);
			err   = code;
			phase = ngga_pkg::PH_SKIP;
		endfunction

		function logic [30:0] coord_to_udeg(logic [16:0] ip, logic [13:0] fp, logic neg);
			longint unsigned scale;
			longint unsigned deg;
			longint unsigned mm;
			longint unsigned v;
			scale = 1;
			for (int i = 0; i < ngga_pkg::MIN_FRAC_DIGITS; i++) scale = scale * 10;
			deg = longint'(ip) / 100;
			mm  = longint'(ip) % 100;
			v   = deg * 1000000 + ((mm * scale + longint'(fp)) * 1000000) / (60 * scale);
			if (neg) v = 0 - v;
			return v[30:0];
		endfunction

		function void parse_char(logic [7:0] c);
			string       hdr;
			logic        dig;
			logic        on_lon;
			logic [3:0]  d;
			hdr    = "$GPGGA";
			dig    = (c >= ngga_pkg::CH_ZERO) && (c <= ngga_pkg::CH_ZERO + 8'd9);
			d      = 4'(c - ngga_pkg::CH_ZERO);
			on_lon = (phase == ngga_pkg::PH_LON_INT) || (phase == ngga_pkg::PH_LON_FRAC);
			case (phase)
				ngga_pkg::PH_PREFIX: begin
					if (cnt < 3'd6 && c == hdr[cnt]) begin
						cnt++;
						if (cnt == 3'd6) begin
							cnt   = '0;
							phase = ngga_pkg::PH_COMMA0;
						end
					end else abort_parse(ngga_pkg::ST_NOTGGA);
				end
				ngga_pkg::PH_COMMA0: begin
					if (c == ngga_pkg::CH_COMMA) phase = ngga_pkg::PH_TIME;
					else abort_parse(ngga_pkg::ST_BAD);
				end
				ngga_pkg::PH_TIME: begin
					if (!dig) abort_parse(ngga_pkg::ST_BAD);
					else begin
						cnt++;
						if (cnt >= 3'd6) begin
							cnt   = '0;
							phase = ngga_pkg::PH_COMMA1;
						end
					end
				end
				ngga_pkg::PH_COMMA1, ngga_pkg::PH_COMMA_LH: begin
					if (c != ngga_pkg::CH_COMMA) abort_parse(ngga_pkg::ST_BAD);
					else begin
						cnt = '0;
						if (phase == ngga_pkg::PH_COMMA1) phase = ngga_pkg::PH_LAT_INT;
						else phase = ngga_pkg::PH_LON_INT;
					end
				end
				ngga_pkg::PH_LAT_INT, ngga_pkg::PH_LON_INT: begin
					if (dig) begin
						if (cnt >= ngga_pkg::INT_DIGITS) abort_parse(ngga_pkg::ST_BAD);
						else begin
							if (on_lon) lon_i = 17'(lon_i * 10 + d);
							else lat_i = 17'(lat_i * 10 + d);
							cnt++;
						end
					end else if (c == ngga_pkg::CH_DOT && cnt != 0) begin
						fcnt = '0;
						if (on_lon) phase = ngga_pkg::PH_LON_FRAC;
						else phase = ngga_pkg::PH_LAT_FRAC;
					end else if (c == ngga_pkg::CH_COMMA && cnt != 0) begin
						if (on_lon) phase = ngga_pkg::PH_LON_HEMI;
						else phase = ngga_pkg::PH_LAT_HEMI;
					end else abort_parse(ngga_pkg::ST_BAD);
				end
				ngga_pkg::PH_LAT_FRAC, ngga_pkg::PH_LON_FRAC: begin
					if (dig) begin
						if (fcnt < ngga_pkg::MIN_FRAC_DIGITS) begin
							if (on_lon) lon_f = 14'(lon_f * 10 + d);
							else lat_f = 14'(lat_f * 10 + d);
							fcnt++;
						end
					end else if (c == ngga_pkg::CH_COMMA) begin
						while (fcnt < ngga_pkg::MIN_FRAC_DIGITS) begin
							if (on_lon) lon_f = 14'(lon_f * 10);
							else lat_f = 14'(lat_f * 10);
							fcnt++;
						end
						if (on_lon) phase = ngga_pkg::PH_LON_HEMI;
						else phase = ngga_pkg::PH_LAT_HEMI;
					end else abort_parse(ngga_pkg::ST_BAD);
				end
				ngga_pkg::PH_LAT_HEMI: begin
					south = (c == ngga_pkg::CH_S);
					phase = ngga_pkg::PH_COMMA_LH;
				end
				ngga_pkg::PH_LON_HEMI: begin
					west  = (c == ngga_pkg::CH_W);
					phase = ngga_pkg::PH_DONE;
				end
				default: ;
			endcase
		endfunction

		function void note_char(logic [7:0] c, logic last);
			gga_fix_t f;
			parse_char(c);
			if (!last) return;
			if (err != ngga_pkg::ST_OK) f.status = err;
			else if (phase == ngga_pkg::PH_PREFIX) f.status = ngga_pkg::ST_NOTGGA;
			else if (phase != ngga_pkg::PH_DONE) f.status = ngga_pkg::ST_BAD;
			else f.status = ngga_pkg::ST_OK;
			if (f.status == ngga_pkg::ST_OK) begin
				f.lat = coord_to_udeg(lat_i, lat_f, south);
				f.lon = coord_to_udeg(lon_i, lon_f, west);
			end else begin
				f.lat = '0;
				f.lon = '0;
			end
			pending_fixes.push_back(f);
			clear_parse();
		endfunction

		function void check_fix(logic [63:0] data);
			gga_fix_t e;
			if (pending_fixes.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result beat: %h", data);
				end
				return;
			end
			e = pending_fixes.pop_front();
			if (data[1:0] !== e.status || data[32:2] !== e.lat || data[63:33] !== e.lon) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("fix mismatch: exp st=%0d lat=%0d lon=%0d, got st=%0d lat=%0d lon=%0d",
						e.status, $signed(e.lat), $signed(e.lon),
						data[1:0], $signed(data[32:2]), $signed(data[63:33]));
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	gga_scoreboard sb = new();
	logic [7:0]    byte_q[$];
	logic          calm;
	int            beats_sent;
	int            stall_cycles = 0;

	nmea_gga_position_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_fix(m_tdata);
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[nmea_gga_position_parser] ERROR");
				$finish;
			end
		end
	end

	task automatic send_char(logic [7:0] c, logic last);
		if (!calm && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_char(c, last);
		beats_sent++;
	endtask

	task automatic send_sentence();
		for (int i = 0; i < byte_q.size(); i++) send_char(byte_q[i], i == byte_q.size() - 1);
		byte_q.delete();
	endtask

	task automatic wait_fixes_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_fixes.size() != 0);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
	endtask

	task automatic push_digits(int n);
		repeat (n) byte_q.push_back(ngga_pkg::CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic push_coord(int typ_len);
		int n;
		int r;
		r = $urandom_range(99);
		if (r < 70) n = typ_len;
		else if (r < 97) n = $urandom_range(1, ngga_pkg::INT_DIGITS);
		else n = ngga_pkg::INT_DIGITS + 1;
		push_digits(n);
		if ($urandom_range(9) >= 2) begin
			byte_q.push_back(ngga_pkg::CH_DOT);
			push_digits(($urandom_range(99) < 60) ? ngga_pkg::MIN_FRAC_DIGITS :
				$urandom_range(0, 7));
		end
	endtask

	task automatic push_hemi(logic [7:0] pos, logic [7:0] neg);
		int r;
		r = $urandom_range(9);
		if (r < 4) byte_q.push_back(pos);
		else if (r < 8) byte_q.push_back(neg);
		else byte_q.push_back(8'($urandom_range(255)));
	endtask

	task automatic build_fix_sentence();
		push_text("$GPGGA,");
		push_digits(6);
		byte_q.push_back(ngga_pkg::CH_COMMA);
		push_coord(4);
		byte_q.push_back(ngga_pkg::CH_COMMA);
		push_hemi("N", ngga_pkg::CH_S);
		byte_q.push_back(ngga_pkg::CH_COMMA);
		push_coord(5);
		byte_q.push_back(ngga_pkg::CH_COMMA);
		push_hemi("E", ngga_pkg::CH_W);
		if ($urandom_range(1)) begin
			repeat ($urandom_range(0, 12)) byte_q.push_back(8'($urandom_range(32, 126)));
		end
	endtask

	initial begin
		string directed[$];
		string near_miss;
		int    kind;
		int    idx;

		directed = '{
			"$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9",
			"$GPGGA,000000,99999.9999,S,99999.9999,W",
			"$GPGGA,235959,99999.9999,N,99999.9999,E",
			"$GPGGA,235959,0,N,0.0000,E",
			"$GPGGA,120000,4807,S,01131,W",
			"$GPGGA,120000,4807.03812345,N,01131.5,X",
			"$GPGGA,120000,12.,N,3.,E",
			"$GPRMC,1",
			"$GP",
			"A",
			"$GPGGAX",
			"$GPGGA,12a456,",
			"$GPGGA,123456X",
			"$GPGGA,123456,,N",
			"$GPGGA,123456,.5,N",
			"$GPGGA,123456,123456.0,N,0,E",
			"$GPGGA,123456,48x7.0,N,0,E",
			"$GPGGA,123456,4807.0x,N",
			"$GPGGA,123456,4807.0,N;0,E",
			"$GPGGA,123456,4807.0,N,01131.0",
			"$GPGGA,123456,4807.0,N,01131.0,"
		};
		near_miss = ",.9SW$";

		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tlast    <= 1'b0;
		calm        = 1'b0;
		beats_sent  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// middle of the directed list runs with no idling on either side
		foreach (directed[i]) begin
			calm = (i >= 8 && i < 16);
			push_text(directed[i]);
			send_sentence();
		end
		calm = 1'b0;
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		send_sentence();
		wait_fixes_drained();

		while (beats_sent < TOTAL_BEATS) begin
			kind = $urandom_range(99);
			if (kind < 87) begin
				build_fix_sentence();
				if (kind >= 55 && kind < 75) begin
					repeat ($urandom_range(1, 2)) begin
						idx = $urandom_range(0, byte_q.size() - 1);
						if ($urandom_range(1)) byte_q[idx] = 8'($urandom_range(255));
						else byte_q[idx] = near_miss[$urandom_range(0, near_miss.len() - 1)];
					end
				end else if (kind >= 75) begin
					idx = $urandom_range(0, byte_q.size() - 1);
					byte_q = byte_q[0:idx];
				end
			end else begin
				if ($urandom_range(1)) byte_q.push_back("$");
				repeat ($urandom_range(1, 10)) byte_q.push_back(8'($urandom_range(255)));
			end
			send_sentence();
			if ($urandom_range(9) == 0) wait_fixes_drained();
		end

		wait_fixes_drained();
		repeat (20) @(posedge clk);
		sb.errors += sb.pending_fixes.size();
		if (sb.errors == 0) $display("[nmea_gga_position_parser] OK");
		else $display("[nmea_gga_position_parser] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
hdl/ngga_pkg.sv
hdl/ngga_front.sv
hdl/ngga_fifo.sv
hdl/ngga_coord.sv
hdl/ngga_back.sv
hdl/nmea_gga_position_parser.sv
tb/sv/tb_nmea_gga_position_parser.sv
